@@ src/swcrc_pkg.sv @@
// Package for the stop-and-wait CRC receiver: widths, CRC constants and shared types.
// Depends on nothing; every other file of the receiver imports it.
`timescale 1ns / 1ps

package swcrc_pkg;

    // Fixed field widths of the channels
    localparam int FRAME_IN_WIDTH  = 32;
    localparam int PAYLOAD_WIDTH   = 15;
    localparam int PAYLOAD_LSB     = 16;
    localparam int WIDE_WIDTH      = 64;

    // Default frame length in bits
    localparam int DEFAULT_FRAME_BITS = 32;

    // CRC-CCITT generator x^16 + x^12 + x^5 + 1, including the top term
    localparam int               CRC_WIDTH = 16;
    localparam logic [CRC_WIDTH:0] CRC_GEN = 17'h11021;

    // Depth of the queue between the classifier and the sequence stage
    localparam int QUEUE_DEPTH = 2;

    // What the classifier hands to the sequence stage for one frame
    typedef struct packed {
        logic                     crc_error;
        logic                     seq_bit;
        logic [PAYLOAD_WIDTH-1:0] data;
    } class_item_t;

    // Remainder of x^pos divided by the generator; used only with constant
    // arguments, so it folds to a constant at elaboration.
    function automatic logic [CRC_WIDTH-1:0] crc_pow_rem(input int pos);
        logic [CRC_WIDTH:0] rem;
        rem = {{CRC_WIDTH{1'b0}}, 1'b1};
        for (int k = 0; k < pos; k++)
        begin
            rem = {rem[CRC_WIDTH-1:0], 1'b0};
            if (rem[CRC_WIDTH])
            begin
                rem = rem ^ CRC_GEN;
            end
        end
        return rem[CRC_WIDTH-1:0];
    endfunction

endpackage

@@ src/swcrc_if.sv @@
// Channel interfaces of the receiver: incoming frames and outgoing results.
// Depends on swcrc_pkg for the field widths.
`timescale 1ns / 1ps

interface swcrc_frame_if
    import swcrc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [FRAME_IN_WIDTH-1:0] frame_bits;

    modport source (output valid, output frame_bits, input ready);
    modport sink   (input valid, input frame_bits, output ready);
endinterface

interface swcrc_result_if
    import swcrc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     ack_bit;
    logic                     accepted;
    logic                     crc_error;
    logic                     duplicate;
    logic [PAYLOAD_WIDTH-1:0] payload;

    modport source (output valid, output ack_bit, output accepted, output crc_error,
                    output duplicate, output payload, input ready);
    modport sink   (input valid, input ack_bit, input accepted, input crc_error,
                    input duplicate, input payload, output ready);
endinterface

@@ src/stop_wait_crc_receiver.sv @@
// Channel      | Direction | Payload
// frame        | in        | frame_bits (32 bits, sequence bit first)
// result       | out       | ack_bit, accepted, crc_error, duplicate, payload (15 bits)
//
// One frame per cycle sustained while the result side is ready. A frame is checked in the
// cycle it is taken and written into a two-entry queue; the sequence stage takes it from
// the queue and registers its result. Reset clears the expected sequence bit to zero and
// empties the queue and output register. A stalled result side fills the queue, after
// which frame.ready falls.
// Depends on swcrc_pkg, swcrc_if, swcrc_classify, swcrc_queue and swcrc_sequence.
`timescale 1ns / 1ps

module stop_wait_crc_receiver
    import swcrc_pkg::*;
#(
    parameter int FRAME_BITS = DEFAULT_FRAME_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    swcrc_frame_if.sink   frame,
    swcrc_result_if.source result
);

    class_item_t classified;
    class_item_t queued;
    logic        queued_valid;
    logic        queued_ready;

    // CRC check and field extraction
    swcrc_classify #(
        .FRAME_BITS (FRAME_BITS)
    ) u_classify (
        .frame_bits (frame.frame_bits),
        .item       (classified)
    );

    // Decoupling queue
    swcrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (frame.valid),
        .push_ready (frame.ready),
        .push_item  (classified),
        .pop_valid  (queued_valid),
        .pop_ready  (queued_ready),
        .pop_item   (queued)
    );

    // Sequence tracking and result register
    swcrc_sequence u_sequence (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queued_valid),
        .item_ready (queued_ready),
        .item       (queued),
        .result     (result)
    );

endmodule

@@ src/swcrc_classify.sv @@
// Front end of the receiver: CRC check and field extraction for one frame.
// Depends on swcrc_pkg; purely combinational, feeds the queue.
`timescale 1ns / 1ps

module swcrc_classify
    import swcrc_pkg::*;
#(
    parameter int FRAME_BITS = DEFAULT_FRAME_BITS
)
(
    input  logic [FRAME_IN_WIDTH-1:0] frame_bits,
    output class_item_t               item
);

    // Frame bits that can actually be set on the input
    localparam int IN_BITS = (FRAME_BITS < FRAME_IN_WIDTH) ? FRAME_BITS : FRAME_IN_WIDTH;
    localparam logic [WIDE_WIDTH-1:0] SEQ_MASK = {{(WIDE_WIDTH-1){1'b0}}, 1'b1} << (FRAME_BITS-1);

    logic [WIDE_WIDTH-1:0] frame_w;
    logic [WIDE_WIDTH-1:0] data_w;
    logic [CRC_WIDTH-1:0]  rem_terms [IN_BITS];
    logic [CRC_WIDTH-1:0]  crc_rem;

    // Frame limited to its length; bits beyond the input port read as zero
    always_comb
    begin
        frame_w = '0;
        frame_w[IN_BITS-1:0] = frame_bits[IN_BITS-1:0];
    end

    // The remainder is linear in the frame: each set bit adds x^i mod G
    for (genvar i = 0; i < IN_BITS; i++)
    begin : g_term
        localparam logic [CRC_WIDTH-1:0] TERM = crc_pow_rem(i);
        assign rem_terms[i] = frame_w[i] ? TERM : '0;
    end

    always_comb
    begin
        crc_rem = '0;
        for (int i = 0; i < IN_BITS; i++)
        begin
            crc_rem = crc_rem ^ rem_terms[i];
        end
    end

    // Data bits sit between the sequence bit and the CRC field
    assign data_w = frame_w & ~SEQ_MASK;

    assign item.crc_error = (crc_rem != '0);
    assign item.seq_bit   = frame_w[FRAME_BITS-1];
    assign item.data      = data_w[PAYLOAD_LSB +: PAYLOAD_WIDTH];

endmodule

@@ src/swcrc_queue.sv @@
// Two-entry queue that decouples the classifier from the sequence stage.
// Depends on swcrc_pkg for the item type and the depth.
`timescale 1ns / 1ps

module swcrc_queue
    import swcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  class_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output class_item_t pop_item
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    class_item_t        store [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/swcrc_sequence.sv @@
// Back end of the receiver: sequence-bit tracking and the registered result.
// Depends on swcrc_pkg and the result interface.
`timescale 1ns / 1ps

module swcrc_sequence
    import swcrc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  class_item_t    item,
    swcrc_result_if.source result
);

    logic                     expected_reg, expected_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     ack_reg, accepted_reg, crc_error_reg, duplicate_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic                     take;
    logic                     ok;
    logic                     dup;

    // A new transaction is taken when the output register is empty or draining
    assign item_ready = !out_valid_reg || result.ready;
    assign take       = item_valid && item_ready;

    // Classification against the expected sequence bit
    assign dup = !item.crc_error && (item.seq_bit != expected_reg);
    assign ok  = !item.crc_error && (item.seq_bit == expected_reg);

    always_comb
    begin
        expected_next  = expected_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            expected_next  = expected_reg ^ ok;
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result fields are loaded with each transaction taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ack_reg       <= !expected_next;
            accepted_reg  <= ok;
            crc_error_reg <= item.crc_error;
            duplicate_reg <= dup;
            payload_reg   <= ok ? item.data : '0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.ack_bit   = ack_reg;
    assign result.accepted  = accepted_reg;
    assign result.crc_error = crc_error_reg;
    assign result.duplicate = duplicate_reg;
    assign result.payload   = payload_reg;

endmodule

@@ dv/stop_wait_crc_receiver_test.sv @@
// Self-checking testbench for stop_wait_crc_receiver: CRC-CCITT frame checks and sequence handling.
// Depends on swcrc_pkg and the channel interfaces in swcrc_if; it drives and samples only the ports.
`timescale 1ns / 1ps

module stop_wait_crc_receiver_test;
    import swcrc_pkg::*;

    localparam int STALL_LIMIT = 500;

    // Expected outcome of one frame
    typedef struct {
        logic                     ack_bit;
        logic                     accepted;
        logic                     crc_error;
        logic                     duplicate;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } rx_outcome_t;

    logic clk;
    logic rst_n;

    swcrc_frame_if  frame();
    swcrc_result_if result();

    stop_wait_crc_receiver DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame.sink),
        .result (result.source)
    );

    rx_outcome_t pending_outcomes[$];
    logic        rx_expected_seq;
    int          mismatch_count;
    int          result_index;
    bit          calm_link;

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Remainder of the whole frame divided by the generator, bit by bit from the top.
    function automatic logic [CRC_WIDTH-1:0] frame_remainder(input logic [FRAME_IN_WIDTH-1:0] f);
        logic [CRC_WIDTH:0] rem;
        rem = '0;
        for (int i = FRAME_IN_WIDTH - 1; i >= 0; i--)
        begin
            rem = {rem[CRC_WIDTH-1:0], f[i]};
            if (rem[CRC_WIDTH])
            begin
                rem = rem ^ CRC_GEN;
            end
        end
        return rem[CRC_WIDTH-1:0];
    endfunction

    // A frame with a correct check field for the given sequence bit and data.
    function automatic logic [FRAME_IN_WIDTH-1:0] build_frame(input logic seq,
                                                             input logic [PAYLOAD_WIDTH-1:0] data);
        logic [FRAME_IN_WIDTH-1:0] body;
        body = {seq, data, {CRC_WIDTH{1'b0}}};
        return body | {{(FRAME_IN_WIDTH-CRC_WIDTH){1'b0}}, frame_remainder(body)};
    endfunction

    // Works out the outcome of one taken frame and advances the expected sequence bit.
    task automatic predict_receiver(input logic [FRAME_IN_WIDTH-1:0] f);
        rx_outcome_t o;
        logic        bad;
        logic        dup;
        bad = (frame_remainder(f) != '0);
        dup = !bad && (f[FRAME_IN_WIDTH-1] != rx_expected_seq);
        o.accepted  = !bad && !dup;
        o.crc_error = bad;
        o.duplicate = dup;
        o.payload   = o.accepted ? f[PAYLOAD_LSB +: PAYLOAD_WIDTH] : '0;
        if (o.accepted)
        begin
            rx_expected_seq = ~rx_expected_seq;
        end
        o.ack_bit = ~rx_expected_seq;
        pending_outcomes.push_back(o);
    endtask

    // Gap length: mostly none or short, now and then long; none while the link is calm.
    function automatic int pick_gap();
        int r;
        if (calm_link)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0h, expected %0h", result_index, what, got, want);
        mismatch_count++;
    endtask

    // Offers one frame and holds it until the transaction completes.
    task automatic send_frame(input logic [FRAME_IN_WIDTH-1:0] f);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            frame.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame.valid      <= 1'b1;
        frame.frame_bits <= f;
        do
        begin
            @(posedge clk);
        end
        while (!frame.ready);
        predict_receiver(f);
    endtask

    // Edge cases: extremes of the data, duplicates and both kinds of CRC error.
    task automatic test_boundary_frames();
        logic [FRAME_IN_WIDTH-1:0] f;
        send_frame('0);                                   // all-zero frame is valid and accepted
        send_frame('0);                                   // the same frame again is a duplicate
        send_frame(build_frame(1'b1, 15'h7FFF));
        send_frame(build_frame(1'b0, 15'h7FFF));
        send_frame(build_frame(1'b1, 15'h0001));
        send_frame(build_frame(1'b0, 15'h4000));
        send_frame('1);
        // CRC error carrying the wrong sequence bit: only the error is flagged.
        f = build_frame(~rx_expected_seq, 15'h2AAA);
        send_frame(f ^ 32'h0000_0001);
        // CRC error carrying the right sequence bit, then the clean retransmission.
        f = build_frame(rx_expected_seq, 15'h5555);
        send_frame(f ^ 32'h0001_0000);
        send_frame(f);
        // A flipped sequence bit is caught by the CRC.
        f = build_frame(rx_expected_seq, 15'h1234);
        send_frame(f ^ 32'h8000_0000);
        send_frame(f);
        // Check field stuck at its extremes.
        send_frame({rx_expected_seq, 15'h3C3C, 16'h0000});
        send_frame({rx_expected_seq, 15'h0F0F, 16'hFFFF});
        // Good frame with the wrong sequence bit and maximum data.
        send_frame(build_frame(~rx_expected_seq, 15'h7FFF));
    endtask

    // Mixed link traffic: mostly in-order frames, with retransmissions, corruption and noise.
    task automatic run_link_traffic(input int count);
        logic [FRAME_IN_WIDTH-1:0] f;
        int                        kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 68)
            begin
                f = build_frame(rx_expected_seq, PAYLOAD_WIDTH'($urandom()));
            end
            else if (kind < 80)
            begin
                f = build_frame(~rx_expected_seq, PAYLOAD_WIDTH'($urandom()));
            end
            else if (kind < 92)
            begin
                f = build_frame(1'($urandom()), PAYLOAD_WIDTH'($urandom()));
                repeat ($urandom_range(1, 3))
                begin
                    f[$urandom_range(0, FRAME_IN_WIDTH - 1)] ^= 1'b1;
                end
            end
            else
            begin
                f = $urandom();
            end
            send_frame(f);
        end
    endtask

    // Frames back to back with the result side always ready.
    task automatic test_back_to_back();
        calm_link = 1'b1;
        run_link_traffic(150);
        calm_link = 1'b0;
    endtask

    // Random traffic with gaps and stalls, with occasional calm stretches.
    task automatic test_link_traffic();
        for (int block = 0; block < 13; block++)
        begin
            calm_link = ($urandom_range(0, 4) == 0);
            run_link_traffic(50);
        end
        calm_link = 1'b0;
    endtask

    // Result side: checks each transaction and stalls at random.
    initial
    begin
        rx_outcome_t want;
        int          stall_left;
        stall_left   = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result.valid && result.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    report_mismatch("result with none expected, payload", result.payload, 0);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result.ack_bit !== want.ack_bit)
                    begin
                        report_mismatch("ack_bit", result.ack_bit, want.ack_bit);
                    end
                    if (result.accepted !== want.accepted)
                    begin
                        report_mismatch("accepted", result.accepted, want.accepted);
                    end
                    if (result.crc_error !== want.crc_error)
                    begin
                        report_mismatch("crc_error", result.crc_error, want.crc_error);
                    end
                    if (result.duplicate !== want.duplicate)
                    begin
                        report_mismatch("duplicate", result.duplicate, want.duplicate);
                    end
                    if (result.payload !== want.payload)
                    begin
                        report_mismatch("payload", result.payload, want.payload);
                    end
                end
                result_index++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                stall_left   = pick_gap();
                result.ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: ends the run when neither channel completes a transaction for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((frame.valid && frame.ready) || (result.valid && result.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("stop_wait_crc_receiver_test: done, errors");
                $finish;
            end
        end
    end

    // Main sequence: reset, the tests in turn, then drain and report.
    initial
    begin
        rx_expected_seq  = 1'b0;
        mismatch_count   = 0;
        result_index     = 0;
        calm_link        = 1'b0;
        rst_n            <= 1'b0;
        frame.valid      <= 1'b0;
        frame.frame_bits <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boundary_frames();
        test_back_to_back();
        test_link_traffic();

        frame.valid <= 1'b0;
        while (pending_outcomes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("stop_wait_crc_receiver_test: done, clean");
        end
        else
        begin
            $display("stop_wait_crc_receiver_test: done, errors");
        end
        $finish;
    end

endmodule
